// ===== rtl/core/icpn_pkg.sv =====
`timescale 1ns / 1ps

package icpn_pkg;

    localparam int FRAC_BITS = 12;
    localparam int COUNT_WIDTH = 17;
    localparam int NUM_SUMS = 27;
    localparam int NUM_ATA = 21;
    localparam int IDX_W = 5;
    localparam int ACC_W = 64;
    localparam int IN_W = 192;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int A_W = 22;
    localparam int PROD_W = 40;

    // One correspondence reduced to the matrix row 0 and its right-hand sides.
    typedef struct packed {
        logic signed [A_W-1:0] n0;
        logic signed [A_W-1:0] n1;
        logic signed [A_W-1:0] n2;
        logic signed [16:0] p0;
        logic signed [16:0] p1;
        logic signed [16:0] p2;
        logic signed [15:0] s0;
        logic signed [15:0] s1;
        logic signed [15:0] s2;
        logic signed [16:0] d0;
        logic signed [16:0] d1;
        logic signed [16:0] d2;
        logic               last;
    } icpn_item_t;

    typedef enum logic [2:0] {
        ST_ACC  = 3'b001,
        ST_EMIT = 3'b010,
        ST_TERM = 3'b100
    } icpn_state_t;

    function automatic logic signed [A_W-1:0] icpn_norm(input logic signed [15:0] a,
                                                        input logic signed [15:0] b);
        logic signed [A_W-1:0] sum;
        begin
            sum = A_W'(a) + A_W'(b);
            if (FRAC_BITS >= 14)
                icpn_norm = sum <<< (FRAC_BITS - 14);
            else
                icpn_norm = (sum + A_W'(1 <<< (13 - FRAC_BITS))) >>> (14 - FRAC_BITS);
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] icpn_sat_add(
        input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] sum;
        begin
            sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (sum[ACC_W] != sum[ACC_W-1])
                icpn_sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
            else
                icpn_sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/icp_normal_equation_accumulator.sv =====
`timescale 1ns / 1ps
// The back end adds one of 27 terms a cycle and takes no new correspondence until all 27 are summed.
// A run end adds an emission of the 27 sums (one transaction per cycle when the sink is ready).
// The results of a run leave through the output register once the last item's terms are summed.
// A four-entry queue decouples input acceptance from the term accumulator.
// Reset (rst_n, asynchronous, active low) clears all sums, the count and sets point_count to 1.

module icp_normal_equation_accumulator
    import icpn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // source_x/y/z, target_x/y/z, source_normal_x/y/z, target_normal_x/y/z
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // entry_value
    output logic [ACC_W-1:0]     m_axis_tdata,
    // entry_index
    output logic [IDX_W-1:0]     m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 cfg_wr_en,
    input  logic [COUNT_WIDTH-1:0] cfg_wr_data
);

    logic [COUNT_WIDTH-1:0] point_count_reg;
    logic                   q_valid;
    logic                   q_ready;
    icpn_item_t             q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_count_reg <= COUNT_WIDTH'(1);
        else if (cfg_wr_en)
            point_count_reg <= cfg_wr_data;
    end

    icpn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_data     (s_axis_tdata),
        .point_count ({1'b0, point_count_reg}),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    icpn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (m_axis_tuser),
        .out_value (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/icpn_front.sv =====
`timescale 1ns / 1ps

module icpn_front
    import icpn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [IN_W-1:0]        in_data,
    input  logic [COUNT_WIDTH:0]   point_count,
    output logic                   q_valid,
    input  logic                   q_ready,
    output icpn_item_t             q_item
);

    icpn_item_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg;
    logic [QPTR_W-1:0]         rd_ptr_reg;
    logic [QPTR_W:0]           fill_reg;
    logic [COUNT_WIDTH-1:0]    seen_reg;
    logic [COUNT_WIDTH-1:0]    seen_next;
    logic [COUNT_WIDTH:0]      limit;
    logic                      push;
    logic                      pop;
    icpn_item_t                item;
    logic signed [15:0]        sv [3];
    logic signed [15:0]        tv [3];

    assign in_ready = (fill_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign q_valid = (fill_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_item = queue_reg[rd_ptr_reg];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sv[i] = in_data[16*i +: 16];
            tv[i] = in_data[48 + 16*i +: 16];
        end
        item.n0 = icpn_norm(in_data[96 +: 16], in_data[144 +: 16]);
        item.n1 = icpn_norm(in_data[112 +: 16], in_data[160 +: 16]);
        item.n2 = icpn_norm(in_data[128 +: 16], in_data[176 +: 16]);
        item.p0 = 17'(sv[0]) + 17'(tv[0]);
        item.p1 = 17'(sv[1]) + 17'(tv[1]);
        item.p2 = 17'(sv[2]) + 17'(tv[2]);
        item.s0 = sv[0];
        item.s1 = sv[1];
        item.s2 = sv[2];
        item.d0 = 17'(tv[0]) - 17'(sv[0]);
        item.d1 = 17'(tv[1]) - 17'(sv[1]);
        item.d2 = 17'(tv[2]) - 17'(sv[2]);
        if (point_count == '0)
            limit = (COUNT_WIDTH+1)'(1);
        else if (point_count > (COUNT_WIDTH+1)'(1 << COUNT_WIDTH))
            limit = (COUNT_WIDTH+1)'(1 << COUNT_WIDTH);
        else
            limit = point_count;
        seen_next = seen_reg + 1'b1;
        item.last = (seen_next == '0) || ({1'b0, seen_next} >= limit);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                seen_reg <= item.last ? '0 : seen_next;
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count slip");

endmodule

// ===== rtl/core/icpn_back.sv =====
`timescale 1ns / 1ps

module icpn_back
    import icpn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  icpn_item_t               q_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         out_index,
    output logic signed [ACC_W-1:0]  out_value,
    output logic                     out_last
);

    // A row per item: [r0 | skew rows] for columns 0..5, one term per cycle.
    icpn_state_t               state_reg;
    logic [IDX_W-1:0]          k_reg;
    logic signed [ACC_W-1:0]   sums_reg [NUM_SUMS];
    icpn_item_t                cur_reg;
    logic signed [A_W-1:0]     a0_reg [6];
    logic signed [A_W-1:0]     b0_reg;
    logic signed [A_W-1:0]     cr [3];
    logic signed [PROD_W-1:0]  c_full [3];
    logic signed [PROD_W-1:0]  dot;
    logic signed [A_W-1:0]     ua [4];
    logic signed [A_W-1:0]     va [4];
    logic signed [ACC_W-1:0]   term_reg;
    logic [IDX_W-1:0]          tk_reg;
    logic                      tv_reg;
    logic signed [ACC_W-1:0]   term;
    logic [2:0]                ci;
    logic [2:0]                cj;
    logic                      emit_fire;
    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic signed [ACC_W-1:0]   out_value_reg;

    localparam logic signed [A_W-1:0] ONE = A_W'(1 << FRAC_BITS);

    assign q_ready = (state_reg == ST_ACC) && !tv_reg;
    assign emit_fire = (state_reg == ST_EMIT) && !tv_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign out_last = (out_index_reg == IDX_W'(NUM_SUMS - 1));

    function automatic logic signed [A_W-1:0] rnd(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        begin
            t = (v + PROD_W'(1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            rnd = t[A_W-1:0];
        end
    endfunction

    always_comb
    begin
        c_full[0] = PROD_W'(q_item.p1) * PROD_W'(q_item.n2)
                  - PROD_W'(q_item.p2) * PROD_W'(q_item.n1);
        c_full[1] = PROD_W'(q_item.p2) * PROD_W'(q_item.n0)
                  - PROD_W'(q_item.p0) * PROD_W'(q_item.n2);
        c_full[2] = PROD_W'(q_item.p0) * PROD_W'(q_item.n1)
                  - PROD_W'(q_item.p1) * PROD_W'(q_item.n0);
        for (int i = 0; i < 3; i++)
            cr[i] = rnd(c_full[i]);
        dot = PROD_W'(q_item.d0) * PROD_W'(q_item.n0) + PROD_W'(q_item.d1) * PROD_W'(q_item.n1)
            + PROD_W'(q_item.d2) * PROD_W'(q_item.n2);
    end

    // Column-to-entry map for index k: (ci, cj), cj = 6 means the b vector.
    always_comb
    begin
        ci = '0;
        cj = '0;
        unique case (k_reg)
            5'd0: begin ci = 3'd0; cj = 3'd0; end
            5'd1: begin ci = 3'd0; cj = 3'd1; end
            5'd2: begin ci = 3'd0; cj = 3'd2; end
            5'd3: begin ci = 3'd0; cj = 3'd3; end
            5'd4: begin ci = 3'd0; cj = 3'd4; end
            5'd5: begin ci = 3'd0; cj = 3'd5; end
            5'd6: begin ci = 3'd1; cj = 3'd1; end
            5'd7: begin ci = 3'd1; cj = 3'd2; end
            5'd8: begin ci = 3'd1; cj = 3'd3; end
            5'd9: begin ci = 3'd1; cj = 3'd4; end
            5'd10: begin ci = 3'd1; cj = 3'd5; end
            5'd11: begin ci = 3'd2; cj = 3'd2; end
            5'd12: begin ci = 3'd2; cj = 3'd3; end
            5'd13: begin ci = 3'd2; cj = 3'd4; end
            5'd14: begin ci = 3'd2; cj = 3'd5; end
            5'd15: begin ci = 3'd3; cj = 3'd3; end
            5'd16: begin ci = 3'd3; cj = 3'd4; end
            5'd17: begin ci = 3'd3; cj = 3'd5; end
            5'd18: begin ci = 3'd4; cj = 3'd4; end
            5'd19: begin ci = 3'd4; cj = 3'd5; end
            5'd20: begin ci = 3'd5; cj = 3'd5; end
            5'd21: begin ci = 3'd0; cj = 3'd6; end
            5'd22: begin ci = 3'd1; cj = 3'd6; end
            5'd23: begin ci = 3'd2; cj = 3'd6; end
            5'd24: begin ci = 3'd3; cj = 3'd6; end
            5'd25: begin ci = 3'd4; cj = 3'd6; end
            5'd26: begin ci = 3'd5; cj = 3'd6; end
            default: begin ci = 3'd0; cj = 3'd0; end
        endcase
    end

    function automatic void col(input logic [2:0] c, input icpn_item_t it,
                                input logic signed [A_W-1:0] a0 [6],
                                input logic signed [A_W-1:0] b0,
                                output logic signed [A_W-1:0] v [4]);
        begin
            v[0] = (c == 3'd6) ? b0 : a0[c];
            v[1] = '0;
            v[2] = '0;
            v[3] = '0;
            case (c)
                3'd0: begin v[2] = -A_W'(it.s2); v[3] = A_W'(it.s1); end
                3'd1: begin v[1] = A_W'(it.s2); v[3] = -A_W'(it.s0); end
                3'd2: begin v[1] = -A_W'(it.s1); v[2] = A_W'(it.s0); end
                3'd3: v[1] = ONE;
                3'd4: v[2] = ONE;
                3'd5: v[3] = ONE;
                3'd6: begin v[1] = A_W'(it.d0); v[2] = A_W'(it.d1); v[3] = A_W'(it.d2); end
                default: v[0] = v[0];
            endcase
        end
    endfunction

    always_comb
    begin
        col(ci, cur_reg, a0_reg, b0_reg, ua);
        col(cj, cur_reg, a0_reg, b0_reg, va);
        term = '0;
        for (int r = 0; r < 4; r++)
            term = term + ACC_W'(ua[r] * va[r]);
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cur_reg <= q_item;
            a0_reg[0] <= cr[0];
            a0_reg[1] <= cr[1];
            a0_reg[2] <= cr[2];
            a0_reg[3] <= q_item.n0;
            a0_reg[4] <= q_item.n1;
            a0_reg[5] <= q_item.n2;
            b0_reg <= rnd(dot);
        end
        term_reg <= term;
        tk_reg <= k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            k_reg <= '0;
            tv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_value_reg <= '0;
            for (int i = 0; i < NUM_SUMS; i++)
                sums_reg[i] <= '0;
        end
        else
        begin
            tv_reg <= (state_reg == ST_TERM);
            if (tv_reg)
                sums_reg[tk_reg] <= icpn_sat_add(sums_reg[tk_reg], term_reg);
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_ACC:
                begin
                    if (q_valid && q_ready)
                    begin
                        state_reg <= ST_TERM;
                        k_reg <= '0;
                    end
                end
                ST_TERM:
                begin
                    if (k_reg == IDX_W'(NUM_SUMS - 1))
                    begin
                        k_reg <= '0;
                        state_reg <= cur_reg.last ? ST_EMIT : ST_ACC;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_index_reg <= k_reg;
                        out_value_reg <= sums_reg[k_reg];
                        sums_reg[k_reg] <= '0;
                        if (k_reg == IDX_W'(NUM_SUMS - 1))
                        begin
                            k_reg <= '0;
                            state_reg <= ST_ACC;
                        end
                        else
                            k_reg <= k_reg + 1'b1;
                    end
                end
                default: state_reg <= ST_ACC;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> (state_reg == ST_TERM && k_reg == '0))
        else $error("item not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !q_ready)
        else $error("item taken during emission");
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < IDX_W'(NUM_SUMS))
        else $error("entry counter out of range");

endmodule
